// ===== rtl/vtm_pkg.sv =====
// Shared types and constants for the virtual timer manager.
// No dependencies; used by vtm_cell and virtual_timer_manager_core.
package vtm_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int SLOTS_MAX       = 64;
  localparam int IDX_W           = 6;     // slot index width at SLOTS_MAX
  localparam int MAX_FIRES       = 8;
  localparam int PER_W           = 40;
  localparam int REM_W           = 41;
  localparam int ELP_W           = 32;
  localparam logic [15:0] EARLY_WINDOW_RST = 16'd1500;
  localparam logic [7:0]  TICKS_PER_US_RST = 8'd8;

  // input functions
  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_START  = 3'd1;
  localparam logic [2:0] FN_STOP   = 3'd2;
  localparam logic [2:0] FN_CHANGE = 3'd3;
  localparam logic [2:0] FN_ADV    = 3'd4;

  // configuration register indexes
  localparam logic [7:0] REG_EARLY_WINDOW = 8'd0;
  localparam logic [7:0] REG_TICKS_PER_US = 8'd1;

  // cell commands
  localparam logic [2:0] CC_NONE    = 3'd0;
  localparam logic [2:0] CC_CREATE  = 3'd1;
  localparam logic [2:0] CC_START   = 3'd2;
  localparam logic [2:0] CC_STOP    = 3'd3;
  localparam logic [2:0] CC_CHANGE  = 3'd4;
  localparam logic [2:0] CC_SUB     = 3'd5;
  localparam logic [2:0] CC_EXTRACT = 3'd6;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] tgt;
    logic [7:0]       id;
    logic [PER_W-1:0] ticks;
    logic             oneshot;
    logic             clrq;
    logic [ELP_W-1:0] elapsed;
  } cmd_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        fidx;
    logic                    hv;
    logic signed [REM_W-1:0] hrem;
    logic [IDX_W-1:0]        hidx;
    logic                    hrun;
    logic [7:0]              hid;
  } carry_t;

endpackage

// ===== rtl/vtm_cell.sv =====
// One timer slot of the cell row: slot state plus one registered search stage.
// Depends on vtm_pkg.
module vtm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  vtm_pkg::cmd_t   cmd,
  input  logic [7:0]      match_id,
  input  logic [CW-1:0]   count,
  input  vtm_pkg::carry_t carry_in,
  output vtm_pkg::carry_t carry_out
);
  import vtm_pkg::*;

  logic [7:0]              id;
  logic [PER_W-1:0]        period;
  logic signed [REM_W-1:0] rem;
  logic                    oneshot;
  logic                    running;
  logic                    queued;

  logic                    sel;
  logic                    used;
  logic                    better;
  logic signed [REM_W:0]   diff;
  logic signed [REM_W-1:0] sub_val;
  carry_t                  carry_next;

  assign sel  = (cmd.tgt == IDX_W'(IDX));
  assign used = (CW'(IDX) < count);
  assign diff = {rem[REM_W-1], rem} - $signed({10'b0, cmd.elapsed});
  // saturate at the most negative 41-bit value
  assign sub_val = (diff[REM_W] && !diff[REM_W-1]) ? {1'b1, {(REM_W-1){1'b0}}}
                                                   : diff[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      queued  <= 1'b0;
    end else begin
      unique case (cmd.op)
        CC_CREATE:  if (sel) begin
          running <= 1'b0;
          if (cmd.clrq) queued <= 1'b0;
        end
        CC_START:   if (sel && !running) begin
          running <= 1'b1;
          queued  <= 1'b1;
        end
        CC_STOP:    if (sel) running <= 1'b0;
        CC_EXTRACT: if (sel) begin
          if (oneshot) begin
            running <= 1'b0;
            queued  <= 1'b0;
          end else begin
            queued <= running;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CC_CREATE:  if (sel) begin
        id      <= cmd.id;
        period  <= cmd.ticks;
        rem     <= $signed({1'b0, cmd.ticks});
        oneshot <= cmd.oneshot;
      end
      CC_CHANGE:  if (sel) period <= cmd.ticks;
      CC_SUB:     rem <= sub_val;
      CC_EXTRACT: if (sel && !oneshot) rem <= $signed({1'b0, period});
      default: ;
    endcase
  end

  // fold this slot into the search word: first id match, then strict minimum
  assign better = queued && (!carry_in.hv || (rem < carry_in.hrem));

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.found && used && (id == match_id)) begin
      carry_next.found = 1'b1;
      carry_next.fidx  = IDX_W'(IDX);
    end
    if (better) begin
      carry_next.hv   = 1'b1;
      carry_next.hrem = rem;
      carry_next.hidx = IDX_W'(IDX);
      carry_next.hrun = running;
      carry_next.hid  = id;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

// ===== rtl/virtual_timer_manager_core.sv =====
// Virtual timer manager top level: command sequencer, config registers, output word.
// Depends on vtm_pkg and vtm_cell.
//
// Manages up to TIMER_SLOTS virtual timers addressed by an 8-bit id. Each slot
// lives in one cell of a row; a search word (first id match, queued timer with
// the smallest remaining count) ripples one cell per clock, so every look at
// the table waits for it to pass the whole row. Create, start, stop and change
// take a search, the operation step, a second search and a final step, and
// give one word. Advance takes a subtract step and a search, then an extract
// step plus one search per timer taken off the queue (up to 8 fires plus one
// silent removal per stopped timer), an output step to release each fire word
// that another fire follows, then a final step and the output step. It gives
// one word per fire or a single non-fire word, the final one marked by m_tlast.
// A new input word is taken only when the sequencer is idle; the output
// register holds a finished word until taken, and the sequencer waits in its
// output step while the sink stalls.
// Configuration: index 0 early_window, index 1 ticks_per_us, always ready.
module virtual_timer_manager_core #(
  parameter int TIMER_SLOTS = vtm_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: func[2:0], tmr_id[10:3], duration_us[42:11], one_shot[43],
  //          elapsed_ticks[75:44], zero fill[79:76]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: ok[0], fired[1], fired_id[9:2], next_valid[10],
  //          next_remaining[42:11], zero fill[47:43]
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vtm_pkg::*;

  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int NW = $clog2(MAX_FIRES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_OP   = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_SUB  = 3'd4;
  localparam logic [2:0] ST_ADV  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]       state, state_next, ret, ret_next;
  logic [CW-1:0]    wait_cnt, wait_cnt_next;
  logic [CW-1:0]    count, count_next;
  logic [15:0]      early_window;
  logic [7:0]       ticks_per_us;

  // latched input word
  logic [2:0]       func;
  logic [7:0]       tmr_id;
  logic [PER_W-1:0] ticks;
  logic             one_shot;
  logic [ELP_W-1:0] elapsed;

  // pending result word
  logic             res_ok, res_ok_next;
  logic             res_fired, res_fired_next;
  logic [7:0]       res_id, res_id_next;
  logic             res_nv, res_nv_next;
  logic [31:0]      res_nr, res_nr_next;
  logic             res_last, res_last_next;
  logic             pend, pend_next;
  logic             need_cap, need_cap_next;
  logic [NW-1:0]    fire_n, fire_n_next;

  cmd_t             cmd;
  carry_t           chain [TIMER_SLOTS+1];
  carry_t           head;
  logic             due;
  logic             out_free;

  assign head      = chain[TIMER_SLOTS];
  assign chain[0]  = '0;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign due       = head.hv && (head.hrem <= $signed({25'b0, early_window}))
                     && (fire_n < NW'(MAX_FIRES));

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    vtm_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .match_id  (tmr_id),
      .count     (count),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      early_window <= EARLY_WINDOW_RST;
      ticks_per_us <= TICKS_PER_US_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_EARLY_WINDOW) early_window <= cfg_data;
      if (cfg_index == REG_TICKS_PER_US) ticks_per_us <= cfg_data[7:0];
    end
  end

  // capture the input word and convert microseconds to ticks
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func     <= s_tdata[2:0];
      tmr_id   <= s_tdata[10:3];
      ticks    <= {8'b0, s_tdata[42:11]} * {32'b0, ticks_per_us};
      one_shot <= s_tdata[43];
      elapsed  <= s_tdata[75:44];
    end
  end

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    wait_cnt_next  = wait_cnt;
    count_next     = count;
    res_ok_next    = res_ok;
    res_fired_next = res_fired;
    res_id_next    = res_id;
    res_nv_next    = res_nv;
    res_nr_next    = res_nr;
    res_last_next  = res_last;
    pend_next      = pend;
    need_cap_next  = need_cap;
    fire_n_next    = fire_n;
    cmd            = '0;
    cmd.id         = tmr_id;
    cmd.ticks      = ticks;
    cmd.oneshot    = one_shot;
    cmd.elapsed    = elapsed;
    cmd.op         = CC_NONE;

    unique case (state)
      ST_IDLE: if (s_tvalid) begin
        // s_tdata func decides the path as the word is taken
        pend_next     = 1'b0;
        need_cap_next = 1'b0;
        fire_n_next   = '0;
        if (s_tdata[2:0] == FN_ADV) begin
          state_next = ST_SUB;
        end else begin
          state_next    = ST_SCAN;
          ret_next      = ST_OP;
          wait_cnt_next = CW'(TIMER_SLOTS - 1);
        end
      end
      ST_SCAN: begin
        // let the search word reach the end of the row
        if (wait_cnt == '0) state_next = ret;
        else wait_cnt_next = wait_cnt - 1'b1;
      end
      ST_OP: begin
        res_ok_next = 1'b0;
        cmd.tgt     = head.fidx;
        unique case (func)
          FN_CREATE: begin
            if (head.found) begin
              cmd.op      = CC_CREATE;
              res_ok_next = 1'b1;
            end else if (count < CW'(TIMER_SLOTS)) begin
              cmd.op      = CC_CREATE;
              cmd.tgt     = IDX_W'(count);
              cmd.clrq    = 1'b1;
              count_next  = count + 1'b1;
              res_ok_next = 1'b1;
            end
          end
          FN_START:  if (head.found) begin
            cmd.op      = CC_START;
            res_ok_next = 1'b1;
          end
          FN_STOP:   if (head.found) begin
            cmd.op      = CC_STOP;
            res_ok_next = 1'b1;
          end
          FN_CHANGE: if (head.found) begin
            cmd.op      = CC_CHANGE;
            res_ok_next = 1'b1;
          end
          default: ;
        endcase
        state_next    = ST_SCAN;
        ret_next      = ST_FIN;
        wait_cnt_next = CW'(TIMER_SLOTS - 1);
      end
      ST_FIN: begin
        res_fired_next = 1'b0;
        res_id_next    = '0;
        res_nv_next    = head.hv;
        res_nr_next    = head.hv ? head.hrem[31:0] : '0;
        res_last_next  = 1'b1;
        state_next     = ST_EMIT;
        ret_next       = ST_IDLE;
      end
      ST_SUB: begin
        cmd.op        = CC_SUB;
        state_next    = ST_SCAN;
        ret_next      = ST_ADV;
        wait_cnt_next = CW'(TIMER_SLOTS - 1);
      end
      ST_ADV: begin
        // queue head after the last fire belongs to that fire's word
        if (need_cap) begin
          res_nv_next   = head.hv;
          res_nr_next   = head.hv ? head.hrem[31:0] : '0;
          need_cap_next = 1'b0;
        end
        if (due) begin
          if (head.hrun && pend) begin
            // another fire follows: release the held word first
            res_last_next = 1'b0;
            state_next    = ST_EMIT;
            ret_next      = ST_ADV;
          end else begin
            cmd.op  = CC_EXTRACT;
            cmd.tgt = head.hidx;
            if (head.hrun) begin
              res_ok_next    = 1'b1;
              res_fired_next = 1'b1;
              res_id_next    = head.hid;
              pend_next      = 1'b1;
              need_cap_next  = 1'b1;
              fire_n_next    = fire_n + 1'b1;
            end
            state_next    = ST_SCAN;
            ret_next      = ST_ADV;
            wait_cnt_next = CW'(TIMER_SLOTS - 1);
          end
        end else begin
          if (!pend) begin
            res_ok_next    = 1'b1;
            res_fired_next = 1'b0;
            res_id_next    = '0;
            res_nv_next    = head.hv;
            res_nr_next    = head.hv ? head.hrem[31:0] : '0;
          end
          res_last_next = 1'b1;
          state_next    = ST_EMIT;
          ret_next      = ST_IDLE;
        end
      end
      ST_EMIT: if (out_free) begin
        pend_next  = 1'b0;
        state_next = ret;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      wait_cnt <= '0;
      count    <= '0;
      pend     <= 1'b0;
      need_cap <= 1'b0;
      fire_n   <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      wait_cnt <= wait_cnt_next;
      count    <= count_next;
      pend     <= pend_next;
      need_cap <= need_cap_next;
      fire_n   <= fire_n_next;
    end
  end

  always_ff @(posedge clk) begin
    res_ok    <= res_ok_next;
    res_fired <= res_fired_next;
    res_id    <= res_id_next;
    res_nv    <= res_nv_next;
    res_nr    <= res_nr_next;
    res_last  <= res_last_next;
  end

  // output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {5'b0, res_nr, res_nv, res_id, res_fired, res_ok};
      m_tlast <= res_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TIMER_SLOTS))
    else $error("slot count beyond table size");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    fire_n <= NW'(MAX_FIRES))
    else $error("too many fires in one advance");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("fire word without ok");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !out_free |=> (state == ST_EMIT))
    else $error("emit left while output still held");
`endif

endmodule
